// ===== hw/rtl/pctt_pkg.sv =====
// Shared types and codes of the periodic callback timer table.
package pctt_pkg;

   localparam int TIME_W   = 64;
   localparam int PERIOD_W = 32;
   localparam int MASK_W   = 8;
   localparam int IDX_W    = 3;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_ARM  = 1'b1;

   typedef struct packed {
      logic load_in;   // capture the accepted request beat
      logic arm_wr;    // write the captured slot
      logic rd_en;     // read one slot of the sweep
      logic load_out;  // move the finished result to the output register
   } cmd_type;

   typedef struct packed {
      logic out_busy;  // output register still holds an untaken beat
   } status_type;

endpackage

// ===== hw/rtl/pctt_if.sv =====
// Request and response channel interfaces of the timer table.
interface pctt_req_if;
   logic                           valid;
   logic                           ready;
   logic                           operation;
   logic [pctt_pkg::IDX_W-1:0]     slot_index;
   logic [pctt_pkg::PERIOD_W-1:0]  period_ticks;

   modport source (output valid, operation, slot_index, period_ticks, input ready);
   modport sink   (input valid, operation, slot_index, period_ticks, output ready);
endinterface

interface pctt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pctt_pkg::MASK_W-1:0]   fired_mask;
   logic [pctt_pkg::TIME_W-1:0]   current_time;

   modport source (output valid, fired_mask, current_time, input ready);
   modport sink   (input valid, fired_mask, current_time, output ready);
endinterface

// ===== hw/rtl/periodic_callback_timer_table.sv =====
// Top level of the periodic callback timer table.
//
//   channel    dir   beat contents
//   req_chan   in    operation, slot_index, period_ticks
//   rsp_chan   out   fired_mask, current_time
//
// A tick reads the slot store once per slot, writes back the last slot (if it
// fired) in the drain state and then loads the result into the output
// register. An arm writes its slot and then loads the result. Requests are
// taken one at a time: the next request is accepted only once the result of
// the last one has been loaded.
// Reset clears the tick counter and all armed bits; the slot store needs no
// clearing. A stalled response holds the result; the next request may still
// be accepted and is worked on, its result waiting for the beat to leave.
module periodic_callback_timer_table #(
   parameter int NUM_SLOTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   pctt_req_if.sink    req_chan,
   pctt_rsp_if.source  rsp_chan
);
   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   pctt_pkg::cmd_type    cmd;
   pctt_pkg::status_type status;
   logic [SLOT_W-1:0]    scan_idx;

   pctt_ctrl #(.NUM_SLOTS(NUM_SLOTS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_chan.operation),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd),
      .scan_idx  (scan_idx)
   );

   pctt_dp #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .scan_idx   (scan_idx),
      .req_op     (req_chan.operation),
      .req_idx    (req_chan.slot_index),
      .req_period (req_chan.period_ticks),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .rsp_mask   (rsp_chan.fired_mask),
      .rsp_time   (rsp_chan.current_time)
   );
endmodule

// ===== hw/rtl/pctt_ram.sv =====
// Generic simple dual-port RAM with registered read.
module pctt_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [AW-1:0]          wr_addr,
   input  logic [WIDTH-1:0]       wr_data,
   input  logic                   rd_en,
   input  logic [AW-1:0]          rd_addr,
   output logic [WIDTH-1:0]       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hw/rtl/pctt_ctrl.sv =====
// Controller: sequences arm writes and the per-tick slot sweep.
module pctt_ctrl #(
   parameter int NUM_SLOTS = 8,
   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_op,
   output logic                  req_ready,
   input  pctt_pkg::status_type  status,
   output pctt_pkg::cmd_type     cmd,
   output logic [SLOT_W-1:0]     scan_idx
);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ARM   = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [SLOT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_in = 1'b1;
               cnt_in      = '0;
               state_in    = (req_op == pctt_pkg::OP_ARM) ? ST_ARM : ST_SCAN;
            end
         end
         ST_ARM: begin
            cmd.arm_wr = 1'b1;
            state_in   = ST_DONE;
         end
         ST_SCAN: begin
            cmd.rd_en = 1'b1;
            if (cnt_ff == LAST_SLOT) begin
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            // last read comes back and is written back here if the slot fired
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!status.out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign scan_idx = cnt_ff;

   a_no_load_when_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !status.out_busy)
      else $error("result loaded over an untaken beat");

   a_sweep_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && cnt_ff == LAST_SLOT) |=> state_ff == ST_DRAIN)
      else $error("sweep did not end after the last slot");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_in, cmd.arm_wr, cmd.rd_en, cmd.load_out}))
      else $error("more than one command at once");
endmodule

// ===== hw/rtl/pctt_dp.sv =====
// Datapath: tick counter, slot store, compare and advance, output register.
module pctt_dp #(
   parameter int NUM_SLOTS = 8,
   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  pctt_pkg::cmd_type                 cmd,
   output pctt_pkg::status_type              status,
   input  logic [SLOT_W-1:0]                 scan_idx,
   input  logic                              req_op,
   input  logic [pctt_pkg::IDX_W-1:0]        req_idx,
   input  logic [pctt_pkg::PERIOD_W-1:0]     req_period,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [pctt_pkg::MASK_W-1:0]       rsp_mask,
   output logic [pctt_pkg::TIME_W-1:0]       rsp_time
);
   localparam int ENT_W  = pctt_pkg::PERIOD_W + pctt_pkg::TIME_W;

   logic [pctt_pkg::TIME_W-1:0]    tick_ff, tick_in;
   logic                           op_ff;
   logic [pctt_pkg::IDX_W-1:0]     idx_ff;
   logic [pctt_pkg::PERIOD_W-1:0]  period_ff;
   logic [NUM_SLOTS-1:0]           armed_ff, armed_in;
   logic                           chk_valid_ff;
   logic [SLOT_W-1:0]              chk_addr_ff;
   logic [pctt_pkg::MASK_W-1:0]    mask_ff, mask_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [pctt_pkg::MASK_W-1:0]    rsp_mask_ff;
   logic [pctt_pkg::TIME_W-1:0]    rsp_time_ff;

   logic                           arm_ok;
   logic                           fire;
   logic                           wr_en;
   logic [SLOT_W-1:0]              wr_addr;
   logic [ENT_W-1:0]               wr_data;
   logic [ENT_W-1:0]               rd_data;
   logic [pctt_pkg::PERIOD_W-1:0]  rd_period;
   logic [pctt_pkg::TIME_W-1:0]    rd_due;

   // slot store: period over due time
   pctt_ram #(.WIDTH(ENT_W), .DEPTH(NUM_SLOTS)) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (scan_idx),
      .rd_data (rd_data)
   );

   assign rd_period = rd_data[ENT_W-1 -: pctt_pkg::PERIOD_W];
   assign rd_due    = rd_data[pctt_pkg::TIME_W-1:0];

   // drop arms to slots beyond the table
   assign arm_ok = cmd.arm_wr && (32'(idx_ff) < 32'(NUM_SLOTS));
   assign fire   = chk_valid_ff && armed_ff[chk_addr_ff] && (rd_due <= tick_ff);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = chk_addr_ff;
      wr_data = {rd_period, rd_due + {{(pctt_pkg::TIME_W-pctt_pkg::PERIOD_W){1'b0}}, rd_period}};
      if (arm_ok) begin
         wr_en   = 1'b1;
         wr_addr = SLOT_W'(idx_ff);
         wr_data = {period_ff,
                    tick_ff + {{(pctt_pkg::TIME_W-pctt_pkg::PERIOD_W){1'b0}}, period_ff}};
      end else if (fire) begin
         wr_en = 1'b1;
      end
   end

   always_comb begin
      armed_in = armed_ff;
      if (arm_ok) begin
         armed_in[SLOT_W'(idx_ff)] = 1'b1;
      end
   end

   always_comb begin
      mask_in = mask_ff;
      if (cmd.load_in) begin
         mask_in = '0;
      end
      for (int b = 0; b < pctt_pkg::MASK_W; b++) begin
         if (fire && (32'(chk_addr_ff) == 32'(b))) begin
            mask_in[b] = 1'b1;
         end
      end
   end

   always_comb begin
      tick_in = tick_ff;
      if (cmd.load_in && req_op == pctt_pkg::OP_TICK) begin
         tick_in = tick_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff      <= '0;
         armed_ff     <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tick_ff      <= tick_in;
         armed_ff     <= armed_in;
         chk_valid_ff <= cmd.rd_en;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_addr_ff <= scan_idx;
      mask_ff     <= mask_in;
      if (cmd.load_in) begin
         op_ff     <= req_op;
         idx_ff    <= req_idx;
         period_ff <= req_period;
      end
      if (cmd.load_out) begin
         rsp_mask_ff <= (op_ff == pctt_pkg::OP_ARM) ? '0 : mask_ff;
         rsp_time_ff <= tick_ff;
      end
   end

   assign status.out_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_mask        = rsp_mask_ff;
   assign rsp_time        = rsp_time_ff;

   a_no_write_clash: assert property (@(posedge clock) disable iff (reset)
      !(cmd.arm_wr && chk_valid_ff))
      else $error("arm write overlaps a sweep write-back");

   a_tick_advances: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_in && req_op == pctt_pkg::OP_TICK) |=> tick_ff == $past(tick_ff) + 1'b1)
      else $error("tick counter did not advance on a tick");

   a_arm_sets_slot: assert property (@(posedge clock) disable iff (reset)
      arm_ok |=> armed_ff != '0)
      else $error("armed slot not marked");
endmodule

// ===== dv/tb_top.sv =====
// Testbench for the periodic callback timer table: directed and random beats vs. a slot model.
module tb_top;

   localparam int SLOT_COUNT   = 8;
   localparam int PHASE_ITEMS  = 610;
   localparam int DRAIN_CYCLES = 20000;

   typedef struct packed {
      logic [pctt_pkg::MASK_W-1:0] fired_mask;
      logic [pctt_pkg::TIME_W-1:0] current_time;
   } tick_report_type;

   typedef struct packed {
      logic                          operation;
      logic [pctt_pkg::IDX_W-1:0]    slot_index;
      logic [pctt_pkg::PERIOD_W-1:0] period_ticks;
      logic                          typed;         // expected report given in the row
      logic [pctt_pkg::MASK_W-1:0]   fired_mask;
      logic [pctt_pkg::TIME_W-1:0]   current_time;
   } timer_stim_type;

   localparam timer_stim_type DIRECTED [0:23] = '{
      '{pctt_pkg::OP_TICK, 3'd0, 32'h0000_0000, 1'b1, 8'h00, 64'd1},
      '{pctt_pkg::OP_ARM,  3'd0, 32'h0000_0001, 1'b1, 8'h00, 64'd1},
      '{pctt_pkg::OP_TICK, 3'd7, 32'hFFFF_FFFF, 1'b1, 8'h01, 64'd2},
      '{pctt_pkg::OP_ARM,  3'd7, 32'hFFFF_FFFF, 1'b1, 8'h00, 64'd2},
      '{pctt_pkg::OP_ARM,  3'd1, 32'h0000_0000, 1'b1, 8'h00, 64'd2},
      '{pctt_pkg::OP_ARM,  3'd2, 32'h0000_0002, 1'b0, 8'h00, 64'd0},
      '{pctt_pkg::OP_ARM,  3'd3, 32'h0000_0003, 1'b0, 8'h00, 64'd0},
      '{pctt_pkg::OP_ARM,  3'd4, 32'h0000_0004, 1'b0, 8'h00, 64'd0},
      '{pctt_pkg::OP_ARM,  3'd5, 32'h0000_0005, 1'b0, 8'h00, 64'd0},
      '{pctt_pkg::OP_ARM,  3'd6, 32'h0000_0006, 1'b0, 8'h00, 64'd0},
      '{pctt_pkg::OP_TICK, 3'd0, 32'h0000_0000, 1'b0, 8'h00, 64'd0},
      '{pctt_pkg::OP_TICK, 3'd5, 32'hA5A5_5A5A, 1'b0, 8'h00, 64'd0},
      '{pctt_pkg::OP_TICK, 3'd0, 32'h0000_0000, 1'b0, 8'h00, 64'd0},
      '{pctt_pkg::OP_TICK, 3'd2, 32'h5A5A_A5A5, 1'b0, 8'h00, 64'd0},
      '{pctt_pkg::OP_TICK, 3'd0, 32'h0000_0000, 1'b0, 8'h00, 64'd0},
      '{pctt_pkg::OP_TICK, 3'd0, 32'h0000_0000, 1'b0, 8'h00, 64'd0},
      '{pctt_pkg::OP_ARM,  3'd2, 32'h0000_0001, 1'b0, 8'h00, 64'd0},
      '{pctt_pkg::OP_TICK, 3'd0, 32'h0000_0000, 1'b0, 8'h00, 64'd0},
      '{pctt_pkg::OP_TICK, 3'd0, 32'h0000_0000, 1'b0, 8'h00, 64'd0},
      '{pctt_pkg::OP_ARM,  3'd1, 32'h8000_0000, 1'b0, 8'h00, 64'd0},
      '{pctt_pkg::OP_TICK, 3'd0, 32'h0000_0000, 1'b0, 8'h00, 64'd0},
      '{pctt_pkg::OP_ARM,  3'd5, 32'h0000_0001, 1'b0, 8'h00, 64'd0},
      '{pctt_pkg::OP_TICK, 3'd0, 32'h0000_0000, 1'b0, 8'h00, 64'd0},
      '{pctt_pkg::OP_TICK, 3'd0, 32'h0000_0000, 1'b0, 8'h00, 64'd0}
   };

   logic clock;
   logic reset;

   pctt_req_if req_chan ();
   pctt_rsp_if rsp_chan ();

   periodic_callback_timer_table #(.NUM_SLOTS(SLOT_COUNT)) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // slot table model
   logic [pctt_pkg::TIME_W-1:0]   model_time;
   logic [SLOT_COUNT-1:0]         model_armed;
   logic [pctt_pkg::PERIOD_W-1:0] model_period [SLOT_COUNT];
   logic [pctt_pkg::TIME_W-1:0]   model_due [SLOT_COUNT];

   tick_report_type pending_reports [$];
   int unsigned     mismatch_count;
   int unsigned     send_idle_pct;
   int unsigned     recv_idle_pct;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic tick_report_type step_timer_table(
      input logic                          op,
      input logic [pctt_pkg::IDX_W-1:0]    idx,
      input logic [pctt_pkg::PERIOD_W-1:0] per);
      tick_report_type rep;
      rep.fired_mask = '0;
      if (op == pctt_pkg::OP_ARM) begin
         if (int'(idx) < SLOT_COUNT) begin
            model_period[idx] = per;
            model_due[idx]    = model_time +
                                {{(pctt_pkg::TIME_W-pctt_pkg::PERIOD_W){1'b0}}, per};
            model_armed[idx]  = 1'b1;
         end
      end else begin
         model_time = model_time + 1'b1;
         for (int k = 0; k < SLOT_COUNT; k++) begin
            if (model_armed[k] && model_due[k] <= model_time) begin
               if (k < pctt_pkg::MASK_W) rep.fired_mask[k] = 1'b1;
               // a late slot only gains one period per tick
               model_due[k] = model_due[k] +
                  {{(pctt_pkg::TIME_W-pctt_pkg::PERIOD_W){1'b0}}, model_period[k]};
            end
         end
      end
      rep.current_time = model_time;
      return rep;
   endfunction

   task automatic send_request(input timer_stim_type row);
      tick_report_type predicted;
      tick_report_type typed_report;
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.operation    <= row.operation;
      req_chan.slot_index   <= row.slot_index;
      req_chan.period_ticks <= row.period_ticks;
      do @(posedge clock); while (!req_chan.ready);
      predicted = step_timer_table(row.operation, row.slot_index, row.period_ticks);
      typed_report.fired_mask   = row.fired_mask;
      typed_report.current_time = row.current_time;
      pending_reports.push_back(row.typed ? typed_report : predicted);
   endtask

   always @(posedge clock) begin
      rsp_chan.ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      tick_report_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_reports.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected beat: mask %h time %0d",
                        rsp_chan.fired_mask, rsp_chan.current_time);
            mismatch_count++;
         end else begin
            want = pending_reports.pop_front();
            if (rsp_chan.fired_mask !== want.fired_mask ||
                rsp_chan.current_time !== want.current_time) begin
               if (mismatch_count < 10)
                  $display("mismatch: mask exp %h got %h, time exp %0d got %0d",
                           want.fired_mask, rsp_chan.fired_mask,
                           want.current_time, rsp_chan.current_time);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      timer_stim_type row;
      int unsigned pick;
      int unsigned waited;
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.operation    = pctt_pkg::OP_TICK;
      req_chan.slot_index   = '0;
      req_chan.period_ticks = '0;
      mismatch_count        = 0;
      model_time            = '0;
      model_armed           = '0;
      send_idle_pct         = 20;
      recv_idle_pct         = 70;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < 24; i++) send_request(DIRECTED[i]);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 70 : 0;
         recv_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 20 : 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            row           = '0;
            row.operation = ($urandom_range(99) < 30) ? pctt_pkg::OP_ARM : pctt_pkg::OP_TICK;
            row.slot_index = pctt_pkg::IDX_W'($urandom);
            // mostly short periods so slots fire often
            pick = $urandom_range(99);
            if (pick < 8)       row.period_ticks = '0;
            else if (pick < 65) row.period_ticks = $urandom_range(16, 1);
            else if (pick < 85) row.period_ticks = $urandom_range(400, 17);
            else                row.period_ticks = $urandom;
            send_request(row);
         end
      end
      req_chan.valid <= 1'b0;

      waited = 0;
      while (pending_reports.size() != 0 && waited < DRAIN_CYCLES) begin
         @(posedge clock);
         waited++;
      end
      repeat (2 * SLOT_COUNT + 8) @(posedge clock);
      if (pending_reports.size() != 0) begin
         $display("%0d beats never arrived", pending_reports.size());
         mismatch_count += pending_reports.size();
      end
      if (mismatch_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb_top: done, errors");
      $finish;
   end

endmodule
